// ----- rtl/vbs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Verlet ball step block.
// Used by every module under rtl; depends on nothing else.
package vbs_pkg;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  localparam logic [64:0] STOP_SQ_Q32 = 65'd10737418;

  typedef enum logic [2:0] {
    CFG_FRICTION    = 3'd0,
    CFG_RESTITUTION = 3'd1,
    CFG_DT_SQUARED  = 3'd2,
    CFG_RADIUS      = 3'd3,
    CFG_WALL_MIN_X  = 3'd4,
    CFG_WALL_MIN_Y  = 3'd5,
    CFG_WALL_MAX_X  = 3'd6,
    CFG_WALL_MAX_Y  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0]        friction_gain;
    logic [15:0]        restitution_gain;
    logic [31:0]        dt_squared;
    logic [30:0]        ball_radius;
    logic signed [31:0] wall_min_x;
    logic signed [31:0] wall_min_y;
    logic signed [31:0] wall_max_x;
    logic signed [31:0] wall_max_y;
  } cfg_t;

  localparam logic [15:0]        RST_FRICTION    = 16'd32440;
  localparam logic [15:0]        RST_RESTITUTION = 16'd26214;
  localparam logic [31:0]        RST_DT_SQUARED  = 32'd1193046;
  localparam logic [30:0]        RST_RADIUS      = 31'd65536;
  localparam logic signed [31:0] RST_WALL_MIN_X  = 32'sd0;
  localparam logic signed [31:0] RST_WALL_MIN_Y  = 32'sd0;
  localparam logic signed [31:0] RST_WALL_MAX_X  = 32'sd52428800;
  localparam logic signed [31:0] RST_WALL_MAX_Y  = 32'sd26214400;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRIC_X,
    ST_FRIC_Y,
    ST_ACC_X,
    ST_ACC_Y,
    ST_SQ_X,
    ST_SQ_Y,
    ST_INTEG,
    ST_CLAMP,
    ST_REST_Y,
    ST_PLACE,
    ST_SPD_X,
    ST_SPD_Y,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MO_FRIC,
    MO_ACC,
    MO_SQV,
    MO_REST,
    MO_SPD
  } mul_op_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_VX,
    ACT_VY,
    ACT_AX,
    ACT_AY,
    ACT_SQ,
    ACT_INT,
    ACT_CLAMP,
    ACT_PREV_X,
    ACT_PREV_Y,
    ACT_PLACE,
    ACT_OUT
  } act_t;

  typedef struct packed {
    logic    mul_en;
    mul_op_t mul_op;
    logic    mul_y;
    act_t    act;
  } ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] res;
    if (v > 66'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/vbs_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register bank: gains, time step, radius and wall positions.
// Depends on vbs_pkg for the register layout, indexes and reset values.
module vbs_cfg_regs
  import vbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.friction_gain    <= RST_FRICTION;
      cfg_r.restitution_gain <= RST_RESTITUTION;
      cfg_r.dt_squared       <= RST_DT_SQUARED;
      cfg_r.ball_radius      <= RST_RADIUS;
      cfg_r.wall_min_x       <= RST_WALL_MIN_X;
      cfg_r.wall_min_y       <= RST_WALL_MIN_Y;
      cfg_r.wall_max_x       <= RST_WALL_MAX_X;
      cfg_r.wall_max_y       <= RST_WALL_MAX_Y;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRICTION:    cfg_r.friction_gain    <= cfg_wdata[15:0];
        CFG_RESTITUTION: cfg_r.restitution_gain <= cfg_wdata[15:0];
        CFG_DT_SQUARED:  cfg_r.dt_squared       <= cfg_wdata;
        CFG_RADIUS:      cfg_r.ball_radius      <= cfg_wdata[30:0];
        CFG_WALL_MIN_X:  cfg_r.wall_min_x       <= $signed(cfg_wdata);
        CFG_WALL_MIN_Y:  cfg_r.wall_min_y       <= $signed(cfg_wdata);
        CFG_WALL_MAX_X:  cfg_r.wall_max_x       <= $signed(cfg_wdata);
        CFG_WALL_MAX_Y:  cfg_r.wall_max_y       <= $signed(cfg_wdata);
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/vbs_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencing state machine: issues multiplier and capture commands to the datapath.
// Depends on vbs_pkg for the state, command and opcode definitions.
module vbs_ctrl
  import vbs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_opcode,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  output ctl_t ctl
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    ctl.mul_en    = 1'b0;
    ctl.mul_op    = MO_FRIC;
    ctl.mul_y     = 1'b0;
    ctl.act       = ACT_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.act   = ACT_LOAD;
          state_nxt = (in_opcode == OP_PLACE) ? ST_PLACE : ST_FRIC_X;
        end
      end
      ST_FRIC_X: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = MO_FRIC;
        state_nxt  = ST_FRIC_Y;
      end
      ST_FRIC_Y: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = MO_FRIC;
        ctl.mul_y  = 1'b1;
        ctl.act    = ACT_VX;
        state_nxt  = ST_ACC_X;
      end
      ST_ACC_X: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = MO_ACC;
        ctl.act    = ACT_VY;
        state_nxt  = ST_ACC_Y;
      end
      ST_ACC_Y: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = MO_ACC;
        ctl.mul_y  = 1'b1;
        ctl.act    = ACT_AX;
        state_nxt  = ST_SQ_X;
      end
      ST_SQ_X: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = MO_SQV;
        ctl.act    = ACT_AY;
        state_nxt  = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = MO_SQV;
        ctl.mul_y  = 1'b1;
        ctl.act    = ACT_SQ;
        state_nxt  = ST_INTEG;
      end
      ST_INTEG: begin
        ctl.act   = ACT_INT;
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = MO_REST;
        ctl.act    = ACT_CLAMP;
        state_nxt  = ST_REST_Y;
      end
      ST_REST_Y: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = MO_REST;
        ctl.mul_y  = 1'b1;
        ctl.act    = ACT_PREV_X;
        state_nxt  = ST_SPD_X;
      end
      ST_PLACE: begin
        ctl.act   = ACT_PLACE;
        state_nxt = ST_SPD_X;
      end
      ST_SPD_X: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = MO_SPD;
        ctl.act    = ACT_PREV_Y;
        state_nxt  = ST_SPD_Y;
      end
      ST_SPD_Y: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = MO_SPD;
        ctl.mul_y  = 1'b1;
        ctl.act    = ACT_SQ;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          ctl.act       = ACT_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in progress");

  a_accept_enters_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_FRIC_X || state_r == ST_PLACE))
    else $error("accepted item did not start a tick or place sequence");

  a_done_holds_while_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_ready) |=> state_r == ST_DONE)
    else $error("result overwritten before the previous item was taken");

  a_done_presents_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && (!out_valid_r || out_ready)) |=> out_valid_r)
    else $error("finished item not presented on the output");

endmodule

// ----- rtl/vbs_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: ball state, shared 33x33 multiplier, integration, wall clamp and
// output registers. Driven by command words from vbs_ctrl; uses vbs_pkg.
module vbs_datapath
  import vbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_t               ctl,
  input  cfg_t               cfg,
  input  logic signed [31:0] in_accel_x,
  input  logic signed [31:0] in_accel_y,
  input  logic signed [31:0] in_place_x,
  input  logic signed [31:0] in_place_y,
  input  logic signed [31:0] in_place_vel_x,
  input  logic signed [31:0] in_place_vel_y,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic [62:0]        out_speed_sq,
  output logic               out_hit_x_wall,
  output logic               out_hit_y_wall
);

  typedef struct packed {
    logic               hit;
    logic signed [31:0] pos;
  } clamp_t;

  function automatic clamp_t clamp_axis(input logic signed [31:0] p,
                                        input logic signed [31:0] lo,
                                        input logic signed [31:0] hi,
                                        input logic [30:0]        rad);
    logic signed [33:0] p_w;
    logic signed [33:0] r_w;
    logic signed [33:0] lo_w;
    logic signed [33:0] hi_w;
    clamp_t             res;
    p_w     = 34'(p);
    r_w     = $signed({3'b000, rad});
    lo_w    = 34'(lo);
    hi_w    = 34'(hi);
    res.hit = 1'b1;
    res.pos = p;
    if (p_w - r_w < lo_w) begin
      res.pos = sat32(66'(lo_w + r_w));
    end else if (p_w + r_w > hi_w) begin
      res.pos = sat32(66'(hi_w - r_w));
    end else begin
      res.hit = 1'b0;
    end
    return res;
  endfunction

  logic signed [31:0] pos_x_r, pos_y_r, prev_x_r, prev_y_r;
  logic               hx_r, hy_r;
  logic signed [31:0] acc_x_r, acc_y_r, plc_x_r, plc_y_r, pvel_x_r, pvel_y_r;
  logic signed [31:0] vx_r, vy_r, ax_r, ay_r;
  logic signed [32:0] vd_x_r, vd_y_r;
  logic [63:0]        sq_r;
  logic signed [65:0] prod_r;
  logic signed [31:0] out_x_r, out_y_r;
  logic [62:0]        out_speed_r;
  logic               out_hx_r, out_hy_r;

  logic signed [32:0] dx, dy, ma, mb;
  logic [64:0]        sq_sum;
  logic               stop;
  logic signed [31:0] vxe, vye, pos_int_x, pos_int_y;
  logic [62:0]        speed;
  clamp_t             cl_x, cl_y;

  assign dx     = 33'(pos_x_r) - 33'(prev_x_r);
  assign dy     = 33'(pos_y_r) - 33'(prev_y_r);
  assign sq_sum = {1'b0, sq_r} + {1'b0, prod_r[63:0]};
  assign stop   = sq_sum < STOP_SQ_Q32;
  assign vxe    = stop ? 32'sd0 : vx_r;
  assign vye    = stop ? 32'sd0 : vy_r;
  assign pos_int_x = sat32(66'(pos_x_r) + 66'(vxe) + 66'(ax_r));
  assign pos_int_y = sat32(66'(pos_y_r) + 66'(vye) + 66'(ay_r));
  assign speed  = (|sq_sum[64:63]) ? '1 : sq_sum[62:0];
  assign cl_x   = clamp_axis(pos_x_r, cfg.wall_min_x, cfg.wall_max_x, cfg.ball_radius);
  assign cl_y   = clamp_axis(pos_y_r, cfg.wall_min_y, cfg.wall_max_y, cfg.ball_radius);

  always_comb begin
    unique case (ctl.mul_op)
      MO_FRIC: begin
        ma = ctl.mul_y ? dy : dx;
        mb = $signed({17'd0, cfg.friction_gain});
      end
      MO_ACC: begin
        ma = ctl.mul_y ? 33'(acc_y_r) : 33'(acc_x_r);
        mb = $signed({1'b0, cfg.dt_squared});
      end
      MO_SQV: begin
        ma = ctl.mul_y ? 33'(vy_r) : 33'(vx_r);
        mb = ma;
      end
      MO_REST: begin
        ma = ctl.mul_y ? vd_y_r : vd_x_r;
        mb = $signed({17'd0, cfg.restitution_gain});
      end
      MO_SPD: begin
        ma = ctl.mul_y ? dy : dx;
        mb = ma;
      end
      default: begin
        ma = dx;
        mb = dx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      prev_x_r <= '0;
      prev_y_r <= '0;
      hx_r     <= 1'b0;
      hy_r     <= 1'b0;
    end else begin
      unique case (ctl.act)
        ACT_INT: begin
          prev_x_r <= pos_x_r;
          prev_y_r <= pos_y_r;
          pos_x_r  <= pos_int_x;
          pos_y_r  <= pos_int_y;
        end
        ACT_CLAMP: begin
          pos_x_r <= cl_x.pos;
          pos_y_r <= cl_y.pos;
          hx_r    <= cl_x.hit;
          hy_r    <= cl_y.hit;
        end
        ACT_PREV_X: begin
          if (hx_r) begin
            prev_x_r <= sat32(66'(pos_x_r) + (prod_r >>> 15));
          end
        end
        ACT_PREV_Y: begin
          if (hy_r) begin
            prev_y_r <= sat32(66'(pos_y_r) + (prod_r >>> 15));
          end
        end
        ACT_PLACE: begin
          pos_x_r  <= plc_x_r;
          pos_y_r  <= plc_y_r;
          prev_x_r <= sat32(66'(plc_x_r) - 66'(pvel_x_r));
          prev_y_r <= sat32(66'(plc_y_r) - 66'(pvel_y_r));
          hx_r     <= 1'b0;
          hy_r     <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= 66'(ma) * 66'(mb);
    end
    unique case (ctl.act)
      ACT_LOAD: begin
        acc_x_r  <= in_accel_x;
        acc_y_r  <= in_accel_y;
        plc_x_r  <= in_place_x;
        plc_y_r  <= in_place_y;
        pvel_x_r <= in_place_vel_x;
        pvel_y_r <= in_place_vel_y;
      end
      ACT_VX:  vx_r <= sat32(prod_r >>> 15);
      ACT_VY:  vy_r <= sat32(prod_r >>> 15);
      ACT_AX:  ax_r <= prod_r[63:32];
      ACT_AY:  ay_r <= prod_r[63:32];
      ACT_SQ:  sq_r <= prod_r[63:0];
      ACT_INT: begin
        vd_x_r <= 33'(pos_int_x) - 33'(pos_x_r);
        vd_y_r <= 33'(pos_int_y) - 33'(pos_y_r);
      end
      ACT_OUT: begin
        out_x_r     <= pos_x_r;
        out_y_r     <= pos_y_r;
        out_speed_r <= speed;
        out_hx_r    <= hx_r;
        out_hy_r    <= hy_r;
      end
      default: begin
      end
    endcase
  end

  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_speed_sq   = out_speed_r;
  assign out_hit_x_wall = out_hx_r;
  assign out_hit_y_wall = out_hy_r;

endmodule

// ----- rtl/verlet_ball_step_with_walls_core.sv -----
`timescale 1ns / 1ps
// Verlet ball step with box walls. Items are taken one at a time; a place item
// skips the integration steps, and the finished state waits while the last result
// is still held. The rate is set by the single shared 33x33 multiplier, used ten
// times per tick. The output register holds a result while the next item is
// accepted. Synchronous active-low reset clears position, previous position and
// control state and loads the register defaults.
module verlet_ball_step_with_walls_core
  import vbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic signed [31:0] in_accel_x,
  input  logic signed [31:0] in_accel_y,
  input  logic signed [31:0] in_place_x,
  input  logic signed [31:0] in_place_y,
  input  logic signed [31:0] in_place_vel_x,
  input  logic signed [31:0] in_place_vel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic [62:0]        out_speed_sq,
  output logic               out_hit_x_wall,
  output logic               out_hit_y_wall
);

  cfg_t cfg;
  ctl_t ctl;

  vbs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  vbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  vbs_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .cfg            (cfg),
    .in_accel_x     (in_accel_x),
    .in_accel_y     (in_accel_y),
    .in_place_x     (in_place_x),
    .in_place_y     (in_place_y),
    .in_place_vel_x (in_place_vel_x),
    .in_place_vel_y (in_place_vel_y),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_speed_sq   (out_speed_sq),
    .out_hit_x_wall (out_hit_x_wall),
    .out_hit_y_wall (out_hit_y_wall)
  );

endmodule

// ----- tb/tb_verlet_ball_step_with_walls_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for verlet_ball_step_with_walls_core: a scoreboard class
// predicts every result in fixed point and compares it field by field with the block.
// Depends on rtl/vbs_pkg.sv and rtl/verlet_ball_step_with_walls_core.sv.
module tb_verlet_ball_step_with_walls_core;
  import vbs_pkg::*;

  typedef logic signed [95:0] w_t;

  typedef struct {
    logic               op;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } ball_item_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [62:0]        speed;
    logic               hx;
    logic               hy;
  } ball_result_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_t;

  localparam int     PX    = 65536;
  localparam longint VEL   = 6 * 65536;
  localparam longint ACC_X = 500 * 65536;
  localparam longint ACC_Y = 2000 * 65536;

  class ball_scoreboard;
    logic [15:0]        friction;
    logic [15:0]        restitution;
    logic [31:0]        dt_sq;
    logic [30:0]        radius;
    logic signed [31:0] min_x, min_y, max_x, max_y;
    logic signed [31:0] pos_x, pos_y, prev_x, prev_y;
    ball_result_t       expected_q[$];
    int                 errors;
    int                 checked;

    function new();
      friction    = RST_FRICTION;
      restitution = RST_RESTITUTION;
      dt_sq       = RST_DT_SQUARED;
      radius      = RST_RADIUS;
      min_x       = RST_WALL_MIN_X;
      min_y       = RST_WALL_MIN_Y;
      max_x       = RST_WALL_MAX_X;
      max_y       = RST_WALL_MAX_Y;
      pos_x       = '0;
      pos_y       = '0;
      prev_x      = '0;
      prev_y      = '0;
      errors      = 0;
      checked     = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 200) $display("ERROR: %s", msg);
    endtask

    function logic signed [31:0] clip_s32(w_t v);
      if (v > 96'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -96'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    function w_t sq_mag(w_t d);
      w_t m;
      m = (d < 0) ? -d : d;
      if (m >= 96'sh1_0000_0000) return 96'sh0_FFFF_FFFF_FFFF_FFFF;
      return m * m;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] val);
      case (idx)
        CFG_FRICTION:    friction = val[15:0];
        CFG_RESTITUTION: restitution = val[15:0];
        CFG_DT_SQUARED:  dt_sq = val;
        CFG_RADIUS:      radius = val[30:0];
        CFG_WALL_MIN_X:  min_x = val;
        CFG_WALL_MIN_Y:  min_y = val;
        CFG_WALL_MAX_X:  max_x = val;
        CFG_WALL_MAX_Y:  max_y = val;
        default: ;
      endcase
    endfunction

    function bit clamp_axis(inout logic signed [31:0] p, inout logic signed [31:0] q,
                            input logic signed [31:0] lo, input logic signed [31:0] hi);
      w_t pw, qw, lw, hw, rw, gw, vw;
      pw = p;
      qw = q;
      lw = lo;
      hw = hi;
      rw = radius;
      gw = restitution;
      vw = pw - qw;
      if (pw - rw < lw) begin
        p = clip_s32(lw + rw);
      end else if (pw + rw > hw) begin
        p = clip_s32(hw - rw);
      end else begin
        return 1'b0;
      end
      pw = p;
      q = clip_s32(pw + ((vw * gw) >>> 15));
      return 1'b1;
    endfunction

    function logic [62:0] speed_now();
      w_t a, b, t, s;
      t = pos_x;
      s = prev_x;
      a = sq_mag(t - s);
      t = pos_y;
      s = prev_y;
      b = sq_mag(t - s);
      t = a + b;
      if (t > 96'sh7FFF_FFFF_FFFF_FFFF) t = 96'sh7FFF_FFFF_FFFF_FFFF;
      return t[62:0];
    endfunction

    function void note_item(ball_item_t it);
      ball_result_t r;
      w_t vx, vy, ax, ay, gain, dt, t, s;
      r.hx = 1'b0;
      r.hy = 1'b0;
      if (it.op == OP_PLACE) begin
        pos_x  = it.px;
        pos_y  = it.py;
        t      = it.px;
        s      = it.vx;
        prev_x = clip_s32(t - s);
        t      = it.py;
        s      = it.vy;
        prev_y = clip_s32(t - s);
      end else begin
        gain = friction;
        dt   = dt_sq;
        t    = pos_x;
        s    = prev_x;
        vx   = clip_s32(((t - s) * gain) >>> 15);
        t    = pos_y;
        s    = prev_y;
        vy   = clip_s32(((t - s) * gain) >>> 15);
        t    = it.ax;
        ax   = (t * dt) >>> 32;
        t    = it.ay;
        ay   = (t * dt) >>> 32;
        if (sq_mag(vx) + sq_mag(vy) < 96'sd10737418) begin
          vx = 0;
          vy = 0;
        end
        prev_x = pos_x;
        prev_y = pos_y;
        t      = pos_x;
        pos_x  = clip_s32(t + vx + ax);
        t      = pos_y;
        pos_y  = clip_s32(t + vy + ay);
        r.hx   = clamp_axis(pos_x, prev_x, min_x, max_x);
        r.hy   = clamp_axis(pos_y, prev_y, min_y, max_y);
      end
      r.x     = pos_x;
      r.y     = pos_y;
      r.speed = speed_now();
      expected_q.push_back(r);
    endfunction

    task check_result(ball_result_t got);
      ball_result_t e;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", checked));
        return;
      end
      e = expected_q.pop_front();
      if (got.x !== e.x)
        report($sformatf("result %0d out_x: got %h, expected %h", checked, got.x, e.x));
      if (got.y !== e.y)
        report($sformatf("result %0d out_y: got %h, expected %h", checked, got.y, e.y));
      if (got.speed !== e.speed)
        report($sformatf("result %0d out_speed_sq: got %h, expected %h",
                         checked, got.speed, e.speed));
      if (got.hx !== e.hx)
        report($sformatf("result %0d out_hit_x_wall: got %b, expected %b",
                         checked, got.hx, e.hx));
      if (got.hy !== e.hy)
        report($sformatf("result %0d out_hit_y_wall: got %b, expected %b",
                         checked, got.hy, e.hy));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_opcode = 1'b0;
  logic signed [31:0] in_accel_x = '0;
  logic signed [31:0] in_accel_y = '0;
  logic signed [31:0] in_place_x = '0;
  logic signed [31:0] in_place_y = '0;
  logic signed [31:0] in_place_vel_x = '0;
  logic signed [31:0] in_place_vel_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic [62:0]        out_speed_sq;
  logic               out_hit_x_wall;
  logic               out_hit_y_wall;

  ball_scoreboard sb;
  cfg_t           cur_cfg;
  int             burst_left = 0;
  bit             no_idle = 1'b0;
  rx_mode_t       rx_mode = RX_ALWAYS;
  int             rx_cnt = 0;
  int             rx_hold = 0;

  verlet_ball_step_with_walls_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_accel_x     (in_accel_x),
    .in_accel_y     (in_accel_y),
    .in_place_x     (in_place_x),
    .in_place_y     (in_place_y),
    .in_place_vel_x (in_place_vel_x),
    .in_place_vel_y (in_place_vel_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_speed_sq   (out_speed_sq),
    .out_hit_x_wall (out_hit_x_wall),
    .out_hit_y_wall (out_hit_y_wall)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    ball_item_t   it;
    ball_result_t got;
    if (rst_n) begin
      if (cfg_we) sb.set_reg(cfg_idx_t'(cfg_index), cfg_wdata);
      if (out_valid && out_ready) begin
        got.x     = out_x;
        got.y     = out_y;
        got.speed = out_speed_sq;
        got.hx    = out_hit_x_wall;
        got.hy    = out_hit_y_wall;
        sb.check_result(got);
      end
      if (in_valid && in_ready) begin
        it.op = in_opcode;
        it.ax = in_accel_x;
        it.ay = in_accel_y;
        it.px = in_place_x;
        it.py = in_place_y;
        it.vx = in_place_vel_x;
        it.vy = in_place_vel_y;
        sb.note_item(it);
      end
    end
  end

  always @(posedge clk) begin
    rx_cnt++;
    if (rx_cnt % 500 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_ALWAYS:   out_ready <= 1'b1;
      RX_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_ready <= (rx_cnt % 9) >= 4;
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 29) == 0) begin
          rx_hold = $urandom_range(10, 40);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  function automatic logic signed [31:0] rand_word();
    return $urandom();
  endfunction

  function automatic logic signed [31:0] pick_range(longint lo, longint hi);
    logic [63:0] rnd;
    logic [63:0] span;
    if (hi < lo) return rand_word();
    rnd  = {$urandom(), $urandom()};
    span = hi - lo + 1;
    return 32'(lo + longint'(rnd % span));
  endfunction

  function automatic ball_item_t tick_item(logic signed [31:0] ax, logic signed [31:0] ay);
    ball_item_t it;
    it.op = OP_TICK;
    it.ax = ax;
    it.ay = ay;
    it.px = rand_word();
    it.py = rand_word();
    it.vx = rand_word();
    it.vy = rand_word();
    return it;
  endfunction

  function automatic ball_item_t place_item(logic signed [31:0] px, logic signed [31:0] py,
                                            logic signed [31:0] vx, logic signed [31:0] vy);
    ball_item_t it;
    it.op = OP_PLACE;
    it.ax = rand_word();
    it.ay = rand_word();
    it.px = px;
    it.py = py;
    it.vx = vx;
    it.vy = vy;
    return it;
  endfunction

  task automatic send_item(input ball_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_opcode      <= it.op;
    in_accel_x     <= it.ax;
    in_accel_y     <= it.ay;
    in_place_x     <= it.px;
    in_place_y     <= it.py;
    in_place_vel_x <= it.vx;
    in_place_vel_y <= it.vy;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    cfg_write(CFG_FRICTION, {16'd0, c.friction_gain});
    cfg_write(CFG_RESTITUTION, {16'd0, c.restitution_gain});
    cfg_write(CFG_DT_SQUARED, c.dt_squared);
    cfg_write(CFG_RADIUS, {1'b0, c.ball_radius});
    cfg_write(CFG_WALL_MIN_X, c.wall_min_x);
    cfg_write(CFG_WALL_MIN_Y, c.wall_min_y);
    cfg_write(CFG_WALL_MAX_X, c.wall_max_x);
    cfg_write(CFG_WALL_MAX_Y, c.wall_max_y);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_cfg = c;
  endtask

  task automatic run_random(input int n);
    int     sent, steps, k;
    longint r, lo_x, hi_x, lo_y, hi_y;
    sent = 0;
    while (sent < n) begin
      k = $urandom_range(0, 99);
      if (k < 75) begin
        r    = cur_cfg.ball_radius;
        lo_x = longint'(cur_cfg.wall_min_x) + r;
        hi_x = longint'(cur_cfg.wall_max_x) - r;
        lo_y = longint'(cur_cfg.wall_min_y) + r;
        hi_y = longint'(cur_cfg.wall_max_y) - r;
        if (hi_x < lo_x) begin
          lo_x = cur_cfg.wall_min_x;
          hi_x = cur_cfg.wall_max_x;
        end
        if (hi_y < lo_y) begin
          lo_y = cur_cfg.wall_min_y;
          hi_y = cur_cfg.wall_max_y;
        end
        send_item(place_item(pick_range(lo_x, hi_x), pick_range(lo_y, hi_y),
                             pick_range(-VEL, VEL), pick_range(-VEL, VEL)));
        steps = $urandom_range(1, 40);
        repeat (steps) send_item(tick_item(pick_range(-ACC_X, ACC_X), pick_range(-ACC_Y, ACC_Y)));
        sent += steps + 1;
      end else if (k < 90) begin
        send_item(tick_item(rand_word(), rand_word()));
        sent++;
      end else begin
        send_item(place_item(rand_word(), rand_word(), rand_word(), rand_word()));
        sent++;
      end
    end
  endtask

  initial begin
    #(18000000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    cfg_t c;
    sb = new();
    cur_cfg.friction_gain    = RST_FRICTION;
    cur_cfg.restitution_gain = RST_RESTITUTION;
    cur_cfg.dt_squared       = RST_DT_SQUARED;
    cur_cfg.ball_radius      = RST_RADIUS;
    cur_cfg.wall_min_x       = RST_WALL_MIN_X;
    cur_cfg.wall_min_y       = RST_WALL_MIN_Y;
    cur_cfg.wall_max_x       = RST_WALL_MAX_X;
    cur_cfg.wall_max_y       = RST_WALL_MAX_Y;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: resting ball, stop threshold either side, each wall, corners, saturation.
    send_item(tick_item(0, 0));
    send_item(place_item(400 * PX, 200 * PX, 3310, 0));
    send_item(tick_item(0, 0));
    send_item(place_item(400 * PX, 200 * PX, 3311, 0));
    send_item(tick_item(0, 0));
    send_item(place_item(400 * PX, 200 * PX, 0, 3000));
    send_item(tick_item(0, 1000 * PX));
    send_item(place_item(PX / 2, 100 * PX, -2 * PX, 0));
    send_item(tick_item(0, 0));
    send_item(place_item(52396032, 100 * PX, 2 * PX, 0));
    send_item(tick_item(0, 0));
    send_item(place_item(400 * PX, PX / 2, 0, -2 * PX));
    send_item(tick_item(0, 0));
    send_item(place_item(400 * PX, 26181632, 0, 2 * PX));
    send_item(tick_item(0, 1000 * PX));
    send_item(place_item(PX / 2, 26181632, -3 * PX, 3 * PX));
    send_item(tick_item(0, 0));
    send_item(place_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF));
    send_item(tick_item(32'sh7FFF_FFFF, 32'sh8000_0000));
    send_item(tick_item(32'sh8000_0000, 32'sh7FFF_FFFF));
    send_item(place_item(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000));
    send_item(tick_item(0, 0));
    send_item(place_item(-1, -1, 32'sh5555_5555, 32'shAAAA_AAAA));
    send_item(tick_item(32'shAAAA_AAAA, 32'sh5555_5555));

    for (int p = 0; p < 8; p++) begin
      c = cur_cfg;
      case (p)
        0: ;
        1: begin
          c.friction_gain    = 16'd32768;
          c.restitution_gain = 16'd32768;
          c.dt_squared       = 32'hFFFF_FFFF;
          c.ball_radius      = '0;
        end
        2: begin
          c.friction_gain    = 16'd0;
          c.restitution_gain = 16'd0;
          c.dt_squared       = 32'd0;
          c.ball_radius      = 31'h7FFF_FFFF;
          c.wall_min_x       = 32'sh8000_0000;
          c.wall_min_y       = 32'sh8000_0000;
          c.wall_max_x       = 32'sh7FFF_FFFF;
          c.wall_max_y       = 32'sh7FFF_FFFF;
        end
        3: begin
          c.friction_gain    = 16'($urandom_range(0, 32768));
          c.restitution_gain = 16'($urandom_range(0, 32768));
          c.dt_squared       = RST_DT_SQUARED;
          c.ball_radius      = RST_RADIUS;
          c.wall_min_x       = 800 * PX;
          c.wall_max_x       = 0;
          c.wall_min_y       = 100 * PX;
          c.wall_max_y       = 100 * PX;
        end
        4: begin
          c.friction_gain    = 16'($urandom_range(32769, 65535));
          c.restitution_gain = 16'($urandom_range(32769, 65535));
          c.dt_squared       = $urandom();
          c.ball_radius      = 31'($urandom_range(0, 20 * PX));
          c.wall_min_x       = pick_range(-1000 * PX, 1000 * PX);
          c.wall_max_x       = c.wall_min_x + pick_range(0, 2000 * PX);
          c.wall_min_y       = pick_range(-1000 * PX, 1000 * PX);
          c.wall_max_y       = c.wall_min_y + pick_range(0, 2000 * PX);
        end
        5: begin
          c.friction_gain    = 16'd32767;
          c.restitution_gain = 16'd1;
          c.dt_squared       = 32'd1;
          c.ball_radius      = 31'd1;
          c.wall_min_x       = 32'sh7FFF_FFFF;
          c.wall_min_y       = 32'sh7FFF_FFFF;
          c.wall_max_x       = 32'sh8000_0000;
          c.wall_max_y       = 32'sh8000_0000;
        end
        6: begin
          c.friction_gain    = 16'($urandom_range(0, 32768));
          c.restitution_gain = 16'($urandom_range(0, 32768));
          c.dt_squared       = $urandom();
          c.ball_radius      = 31'($urandom());
          c.wall_min_x       = $urandom();
          c.wall_min_y       = $urandom();
          c.wall_max_x       = $urandom();
          c.wall_max_y       = $urandom();
        end
        default: begin
          c.friction_gain    = RST_FRICTION;
          c.restitution_gain = RST_RESTITUTION;
          c.dt_squared       = RST_DT_SQUARED * 4;
          c.ball_radius      = 31'(4 * PX);
          c.wall_min_x       = RST_WALL_MIN_X;
          c.wall_min_y       = RST_WALL_MIN_Y;
          c.wall_max_x       = RST_WALL_MAX_X;
          c.wall_max_y       = RST_WALL_MAX_Y;
        end
      endcase
      wait_for_results();
      apply_config(c);
      no_idle    = (p % 3 == 2);
      burst_left = 0;
      run_random(215);
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
